FILE: hw/rtl/fpb_pkg.sv
// ----------------------------------------------------------------------------
// fpb_pkg
// Shared types and constants for the float power-by-squaring block.
// ----------------------------------------------------------------------------
package fpb_pkg;

  localparam int EXP_BITS_DEFAULT = 16;

  // binary64 constants
  localparam logic [63:0] FP_ONE      = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] FP_DFLT_NAN = 64'hFFF8_0000_0000_0000;
  localparam logic [63:0] FP_QUIET    = 64'h0008_0000_0000_0000;

  // last iteration index of the shared unit's multiply and divide loops
  localparam logic [5:0] MUL_LAST = 6'd4;
  localparam logic [5:0] DIV_LAST = 6'd55;

  typedef enum logic {
    FPU_MUL,
    FPU_DIV
  } fpu_op_t;

  typedef struct packed {
    logic    start;
    fpu_op_t op;
  } fpu_req_t;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_NORM,
    FS_MUL,
    FS_DIV,
    FS_ALIGN,
    FS_DENORM,
    FS_ROUND,
    FS_DONE
  } fpu_state_t;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_RECIP,
    SQ_RWAIT,
    SQ_STORE,
    SQ_SWAIT,
    SQ_PICK,
    SQ_CWAIT,
    SQ_OUT
  } seq_state_t;

endpackage

FILE: hw/rtl/fpb_in_if.sv
// ----------------------------------------------------------------------------
// fpb_in_if
// Input channel: base bit pattern and signed exponent with valid/ready.
// ----------------------------------------------------------------------------
interface fpb_in_if #(
  parameter int EXP_BITS = fpb_pkg::EXP_BITS_DEFAULT
) ();
  logic                       valid;
  logic                       ready;
  logic [63:0]                base_bits;
  logic signed [EXP_BITS-1:0] exponent;

  modport source (output valid, base_bits, exponent, input ready);
  modport sink   (input valid, base_bits, exponent, output ready);
endinterface

FILE: hw/rtl/fpb_out_if.sv
// ----------------------------------------------------------------------------
// fpb_out_if
// Output channel: result bit pattern with valid/ready.
// ----------------------------------------------------------------------------
interface fpb_out_if ();
  logic        valid;
  logic        ready;
  logic [63:0] result_bits;

  modport source (output valid, result_bits, input ready);
  modport sink   (input valid, result_bits, output ready);
endinterface

FILE: hw/rtl/float_power_by_squaring.sv
// ----------------------------------------------------------------------------
// float_power_by_squaring
// binary64 base raised to a signed integer power by repeated squaring.
// ----------------------------------------------------------------------------
// One item at a time on a single shared multiply/divide unit. A negative
// exponent first costs one divide for the reciprocal. After that, each
// exponent bit below the top set bit costs one squaring, and each set bit
// costs one combining multiply. Subnormal operands or results add
// normalizing and denormalizing steps to a multiply or a divide. NaN,
// infinite and zero operands finish without iterating. A zero exponent
// presents 1.0 the cycle after the transfer. The input is not ready until
// the result has been transferred.
// ----------------------------------------------------------------------------
module float_power_by_squaring #(
  parameter int EXP_BITS = fpb_pkg::EXP_BITS_DEFAULT
) (
  input logic clk,
  input logic rst,
  fpb_in_if.sink    in_item,
  fpb_out_if.source out_item
);

  localparam int LW = $clog2(EXP_BITS);

  fpb_pkg::seq_state_t state, state_next;

  logic [63:0]         b;
  logic [63:0]         acc;
  logic [EXP_BITS-1:0] mag;
  logic [LW-1:0]       level;
  logic [63:0]         fac [EXP_BITS];

  fpb_pkg::fpu_req_t req;
  logic [63:0]       opa, opb;
  logic              fdone;
  logic [63:0]       fres;

  fpb_fpu u_fpu (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .a      (opa),
    .b      (opb),
    .done   (fdone),
    .result (fres)
  );

  // magnitude and sign of the incoming exponent
  logic [EXP_BITS-1:0] e_u, e_mag;
  logic                e_neg;
  assign e_u   = in_item.exponent;
  assign e_neg = e_u[EXP_BITS-1];
  assign e_mag = e_neg ? (~e_u + {{(EXP_BITS-1){1'b0}}, 1'b1}) : e_u;

  // set bits remain above the current level
  logic [EXP_BITS-1:0] upper;
  logic                more;
  assign upper = mag >> level;
  assign more  = |upper[EXP_BITS-1:1];

  logic in_xfer, out_xfer;
  assign in_xfer  = in_item.valid && in_item.ready;
  assign out_xfer = out_item.valid && out_item.ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      fpb_pkg::SQ_IDLE: begin
        if (in_xfer) begin
          if (e_mag == '0)  state_next = fpb_pkg::SQ_OUT;
          else if (e_neg)   state_next = fpb_pkg::SQ_RECIP;
          else              state_next = fpb_pkg::SQ_STORE;
        end
      end
      fpb_pkg::SQ_RECIP: state_next = fpb_pkg::SQ_RWAIT;
      fpb_pkg::SQ_RWAIT: if (fdone) state_next = fpb_pkg::SQ_STORE;
      fpb_pkg::SQ_STORE: state_next = more ? fpb_pkg::SQ_SWAIT : fpb_pkg::SQ_PICK;
      fpb_pkg::SQ_SWAIT: if (fdone) state_next = fpb_pkg::SQ_STORE;
      fpb_pkg::SQ_PICK: begin
        if (mag[level])          state_next = fpb_pkg::SQ_CWAIT;
        else if (level == '0)    state_next = fpb_pkg::SQ_OUT;
      end
      fpb_pkg::SQ_CWAIT: begin
        if (fdone) state_next = (level == '0) ? fpb_pkg::SQ_OUT : fpb_pkg::SQ_PICK;
      end
      fpb_pkg::SQ_OUT: if (out_xfer) state_next = fpb_pkg::SQ_IDLE;
      default:         state_next = fpb_pkg::SQ_IDLE;
    endcase
  end

  // outputs and shared unit requests
  always_comb begin
    in_item.ready        = (state == fpb_pkg::SQ_IDLE);
    out_item.valid       = (state == fpb_pkg::SQ_OUT);
    out_item.result_bits = acc;
    req.start            = 1'b0;
    req.op               = fpb_pkg::FPU_MUL;
    opa                  = b;
    opb                  = b;
    unique case (state)
      fpb_pkg::SQ_RECIP: begin
        req.start = 1'b1;
        req.op    = fpb_pkg::FPU_DIV;
        opa       = fpb_pkg::FP_ONE;
      end
      fpb_pkg::SQ_STORE: begin
        req.start = more;
      end
      fpb_pkg::SQ_PICK: begin
        req.start = mag[level];
        opa       = fac[level];
        opb       = acc;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fpb_pkg::SQ_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      fpb_pkg::SQ_IDLE: begin
        if (in_xfer) begin
          b     <= in_item.base_bits;
          mag   <= e_mag;
          level <= '0;
          acc   <= fpb_pkg::FP_ONE;
        end
      end
      fpb_pkg::SQ_RWAIT: begin
        if (fdone) b <= fres;
      end
      fpb_pkg::SQ_STORE: begin
        // hold this level's base for the combining pass
        fac[level] <= b;
      end
      fpb_pkg::SQ_SWAIT: begin
        if (fdone) begin
          b     <= fres;
          level <= LW'(level + 1'b1);
        end
      end
      fpb_pkg::SQ_PICK: begin
        if (!mag[level] && level != '0) level <= LW'(level - 1'b1);
      end
      fpb_pkg::SQ_CWAIT: begin
        if (fdone) begin
          acc <= fres;
          if (level != '0) level <= LW'(level - 1'b1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: hw/rtl/fpb_fpu.sv
// ----------------------------------------------------------------------------
// fpb_fpu
// Iterative binary64 multiply / divide with round-to-nearest-even.
// ----------------------------------------------------------------------------
module fpb_fpu (
  input  logic             clk,
  input  logic             rst,
  input  fpb_pkg::fpu_req_t req,
  input  logic [63:0]      a,
  input  logic [63:0]      b,
  output logic             done,
  output logic [63:0]      result
);

  fpb_pkg::fpu_state_t state, state_next;
  fpb_pkg::fpu_op_t    op;

  logic               sign;
  logic [52:0]        ma, mb;
  logic signed [13:0] ea, eb, ex;
  logic [105:0]       r;
  logic [53:0]        rem;
  logic [5:0]         cnt;
  logic [53:0]        pp;
  logic [1:0]         psh;

  // operand classes
  logic a_nan, a_inf, a_zero, b_nan, b_inf, b_zero, s_ab;
  logic sp_hit;
  logic [63:0] sp_val;

  assign a_nan  = (&a[62:52]) && (|a[51:0]);
  assign a_inf  = (&a[62:52]) && !(|a[51:0]);
  assign a_zero = !(|a[62:0]);
  assign b_nan  = (&b[62:52]) && (|b[51:0]);
  assign b_inf  = (&b[62:52]) && !(|b[51:0]);
  assign b_zero = !(|b[62:0]);
  assign s_ab   = a[63] ^ b[63];

  // resolve NaN, infinity and zero operands without iterating
  always_comb begin
    sp_hit = 1'b1;
    sp_val = '0;
    if (a_nan) begin
      sp_val = a | fpb_pkg::FP_QUIET;
    end else if (b_nan) begin
      sp_val = b | fpb_pkg::FP_QUIET;
    end else if (req.op == fpb_pkg::FPU_MUL) begin
      if ((a_inf && b_zero) || (a_zero && b_inf)) begin
        sp_val = fpb_pkg::FP_DFLT_NAN;
      end else if (a_inf || b_inf) begin
        sp_val = {s_ab, 11'h7FF, 52'd0};
      end else if (a_zero || b_zero) begin
        sp_val = {s_ab, 63'd0};
      end else begin
        sp_hit = 1'b0;
      end
    end else begin
      if ((a_zero && b_zero) || (a_inf && b_inf)) begin
        sp_val = fpb_pkg::FP_DFLT_NAN;
      end else if (a_inf || b_zero) begin
        sp_val = {s_ab, 11'h7FF, 52'd0};
      end else if (a_zero || b_inf) begin
        sp_val = {s_ab, 63'd0};
      end else begin
        sp_hit = 1'b0;
      end
    end
  end

  // partial product operands: 27-bit chunks of the mantissas
  logic [26:0] xa, xb;
  logic [105:0] pp_ext;
  assign xa = cnt[0] ? {1'b0, ma[52:27]} : ma[26:0];
  assign xb = cnt[1] ? {1'b0, mb[52:27]} : mb[26:0];

  always_comb begin
    case (psh)
      2'd0:    pp_ext = {52'd0, pp};
      2'd1:    pp_ext = {25'd0, pp, 27'd0};
      default: pp_ext = {pp[51:0], 54'd0};
    endcase
  end

  // restoring divide step
  logic        ge;
  logic [53:0] rsub;
  assign ge   = rem >= {1'b0, mb};
  assign rsub = ge ? (rem - {1'b0, mb}) : rem;

  // round to nearest even
  logic               inc;
  logic [53:0]        m54;
  logic signed [13:0] ef;
  logic [63:0]        rounded;
  always_comb begin
    inc = r[52] & (r[53] | (|r[51:0]));
    m54 = {1'b0, r[105:53]} + {53'd0, inc};
    if (m54[53]) begin
      ef = ex + 14'sd1;
    end else if (m54[52]) begin
      ef = ex;
    end else begin
      ef = 14'sd0;
    end
    if (ef >= 14'sd2047) begin
      rounded = {sign, 11'h7FF, 52'd0};
    end else begin
      rounded = {sign, ef[10:0], (m54[53] ? 52'd0 : m54[51:0])};
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      fpb_pkg::FS_IDLE: begin
        if (req.start) state_next = sp_hit ? fpb_pkg::FS_DONE : fpb_pkg::FS_NORM;
      end
      fpb_pkg::FS_NORM: begin
        if (ma[52] && mb[52]) begin
          state_next = (op == fpb_pkg::FPU_DIV) ? fpb_pkg::FS_DIV : fpb_pkg::FS_MUL;
        end
      end
      fpb_pkg::FS_MUL: begin
        if (cnt == fpb_pkg::MUL_LAST) state_next = fpb_pkg::FS_ALIGN;
      end
      fpb_pkg::FS_DIV: begin
        if (cnt == fpb_pkg::DIV_LAST) state_next = fpb_pkg::FS_ALIGN;
      end
      fpb_pkg::FS_ALIGN: begin
        if (r[105]) state_next = fpb_pkg::FS_DENORM;
      end
      fpb_pkg::FS_DENORM: begin
        if (ex >= 14'sd1 || ex < -14'sd54) state_next = fpb_pkg::FS_ROUND;
      end
      fpb_pkg::FS_ROUND: state_next = fpb_pkg::FS_DONE;
      fpb_pkg::FS_DONE:  state_next = fpb_pkg::FS_IDLE;
      default:           state_next = fpb_pkg::FS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    done = (state == fpb_pkg::FS_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fpb_pkg::FS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      fpb_pkg::FS_IDLE: begin
        if (req.start) begin
          op     <= req.op;
          sign   <= s_ab;
          result <= sp_val;
          ma     <= {|a[62:52], a[51:0]};
          mb     <= {|b[62:52], b[51:0]};
          ea     <= (a[62:52] == 11'd0) ? 14'sd1 : $signed({3'd0, a[62:52]});
          eb     <= (b[62:52] == 11'd0) ? 14'sd1 : $signed({3'd0, b[62:52]});
          cnt    <= '0;
        end
      end
      fpb_pkg::FS_NORM: begin
        // bring subnormal mantissas to a leading one
        if (!ma[52]) begin
          ma <= {ma[51:0], 1'b0};
          ea <= ea - 14'sd1;
        end
        if (!mb[52]) begin
          mb <= {mb[51:0], 1'b0};
          eb <= eb - 14'sd1;
        end
        if (ma[52] && mb[52]) begin
          r   <= '0;
          cnt <= '0;
          rem <= {1'b0, ma};
          ex  <= (op == fpb_pkg::FPU_DIV) ? (ea - eb + 14'sd1023) : (ea + eb - 14'sd1022);
        end
      end
      fpb_pkg::FS_MUL: begin
        // one partial product per cycle, accumulated in the following cycle
        cnt <= cnt + 6'd1;
        if (cnt != 6'd0) r <= r + pp_ext;
        pp  <= xa * xb;
        psh <= (cnt == 6'd3) ? 2'd2 : ((cnt == 6'd0) ? 2'd0 : 2'd1);
      end
      fpb_pkg::FS_DIV: begin
        cnt <= cnt + 6'd1;
        rem <= {rsub[52:0], 1'b0};
        if (cnt == fpb_pkg::DIV_LAST) begin
          r <= {r[54:0], ge, 49'd0, |rsub};
        end else begin
          r <= {r[104:0], ge};
        end
      end
      fpb_pkg::FS_ALIGN: begin
        if (!r[105]) begin
          r  <= {r[104:0], 1'b0};
          ex <= ex - 14'sd1;
        end
      end
      fpb_pkg::FS_DENORM: begin
        // shift into the subnormal range, folding lost bits into sticky
        if (ex < 14'sd1) begin
          if (ex < -14'sd54) begin
            r  <= 106'd1;
            ex <= 14'sd1;
          end else begin
            r  <= {1'b0, r[105:2], r[1] | r[0]};
            ex <= ex + 14'sd1;
          end
        end
      end
      fpb_pkg::FS_ROUND: begin
        result <= rounded;
      end
      default: begin
      end
    endcase
  end

endmodule
